FILE: rtl/core/glr_pkg.sv
// Shared types, constants and register codes of the grid line rasteriser
package glr_pkg;

  localparam int COORD_W          = 16;
  localparam int DIV_W            = 16;
  localparam int CELL_SIZE_W      = 10;
  localparam int GRID_REG_W       = 7;
  localparam int CELL_W           = 6;
  localparam int MAX_GRID_DEFAULT = 64;
  localparam int APB_ADDR_W       = 5;
  localparam int APB_DATA_W       = 32;

  localparam logic signed [COORD_W-1:0]   ORIGIN_RESET    = -16'sd5200;
  localparam logic [CELL_SIZE_W-1:0]      CELL_SIZE_RESET = 10'd50;
  localparam logic [GRID_REG_W-1:0]       GRID_RESET      = 7'd64;

  typedef enum logic [2:0] {
    REG_ORIGIN_X    = 3'd0,
    REG_ORIGIN_Y    = 3'd1,
    REG_CELL_SIZE   = 3'd2,
    REG_GRID_WIDTH  = 3'd3,
    REG_GRID_HEIGHT = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_START,
    S_DIV_WAIT,
    S_SETUP,
    S_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic [CELL_SIZE_W-1:0]    cell_size;
    logic [GRID_REG_W-1:0]     grid_w;
    logic [GRID_REG_W-1:0]     grid_h;
  } cfg_t;

  typedef struct packed {
    logic       load;
    logic       div_start;
    logic       div_store;
    logic [1:0] sel;
    logic       setup;
    logic       step;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic at_end;
  } dp_status_t;

endpackage

FILE: rtl/core/glr_if.sv
// Segment and cell item channels
interface glr_seg_if import glr_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] start_x;
  logic signed [COORD_W-1:0] start_y;
  logic signed [COORD_W-1:0] end_x;
  logic signed [COORD_W-1:0] end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface glr_cell_if import glr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cell_x;
  logic [CELL_W-1:0] cell_y;
  logic              last_cell;

  modport source (output valid, cell_x, cell_y, last_cell, input ready);
  modport sink   (input valid, cell_x, cell_y, last_cell, output ready);
endinterface

FILE: rtl/core/glr_cfg.sv
// Configuration registers behind the APB port, with effective values
module glr_cfg import glr_pkg::*; #(
  parameter int MAX_GRID = MAX_GRID_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output cfg_t                  cfg
);

  logic signed [COORD_W-1:0] origin_x;
  logic signed [COORD_W-1:0] origin_y;
  logic [CELL_SIZE_W-1:0]    cell_size;
  logic [GRID_REG_W-1:0]     grid_width;
  logic [GRID_REG_W-1:0]     grid_height;
  logic                      wr;
  logic [2:0]                idx;

  assign wr  = psel && penable && pwrite;
  assign idx = paddr[APB_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x    <= ORIGIN_RESET;
      origin_y    <= ORIGIN_RESET;
      cell_size   <= CELL_SIZE_RESET;
      grid_width  <= GRID_RESET;
      grid_height <= GRID_RESET;
    end else if (wr) begin
      unique case (idx)
        REG_ORIGIN_X:    origin_x    <= signed'(pwdata[COORD_W-1:0]);
        REG_ORIGIN_Y:    origin_y    <= signed'(pwdata[COORD_W-1:0]);
        REG_CELL_SIZE:   cell_size   <= pwdata[CELL_SIZE_W-1:0];
        REG_GRID_WIDTH:  grid_width  <= pwdata[GRID_REG_W-1:0];
        REG_GRID_HEIGHT: grid_height <= pwdata[GRID_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ORIGIN_X:    prdata = APB_DATA_W'(origin_x);
      REG_ORIGIN_Y:    prdata = APB_DATA_W'(origin_y);
      REG_CELL_SIZE:   prdata = APB_DATA_W'(cell_size);
      REG_GRID_WIDTH:  prdata = APB_DATA_W'(grid_width);
      REG_GRID_HEIGHT: prdata = APB_DATA_W'(grid_height);
      default:         prdata = '0;
    endcase
  end

  function automatic logic [GRID_REG_W-1:0] eff_grid(input logic [GRID_REG_W-1:0] g);
    logic [GRID_REG_W-1:0] r;
    if (g == '0)
      r = GRID_REG_W'(1);
    else if (g > GRID_REG_W'(MAX_GRID))
      r = GRID_REG_W'(MAX_GRID);
    else
      r = g;
    return r;
  endfunction

  always_comb begin
    cfg.origin_x  = origin_x;
    cfg.origin_y  = origin_y;
    cfg.cell_size = (cell_size == '0) ? CELL_SIZE_W'(1) : cell_size;
    cfg.grid_w    = eff_grid(grid_width);
    cfg.grid_h    = eff_grid(grid_height);
  end

endmodule

FILE: rtl/core/glr_div.sv
// Restoring divider, one quotient bit per cycle
module glr_div import glr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [DIV_W-1:0]       dividend,
  input  logic [CELL_SIZE_W-1:0] divisor,
  output logic [DIV_W-1:0]       quotient,
  output logic                   done
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [CELL_SIZE_W-1:0] rem;
  logic [CELL_SIZE_W-1:0] dvs;
  logic [DIV_W-1:0]       quo;
  logic [CNT_W-1:0]       cnt;
  logic                   busy;
  logic [CELL_SIZE_W:0]   trial;
  logic                   fits;

  assign trial    = {rem, quo[DIV_W-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? CELL_SIZE_W'(trial - {1'b0, dvs}) : trial[CELL_SIZE_W-1:0];
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

endmodule

FILE: rtl/core/glr_dp.sv
// Datapath: endpoint to cell conversion and Bresenham stepping
module glr_dp import glr_pkg::*; #(
  parameter int MAX_GRID = MAX_GRID_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cfg_t                      cfg,
  input  dp_cmd_t                   cmd,
  output dp_status_t                status,
  input  logic signed [COORD_W-1:0] start_x,
  input  logic signed [COORD_W-1:0] start_y,
  input  logic signed [COORD_W-1:0] end_x,
  input  logic signed [COORD_W-1:0] end_y,
  output logic [CELL_W-1:0]         cell_x,
  output logic [CELL_W-1:0]         cell_y,
  output logic                      last_cell
);

  localparam int CW = $clog2(MAX_GRID);
  localparam int EW = CW + 3;

  logic signed [COORD_W-1:0] pt [4];
  logic signed [COORD_W-1:0] world;
  logic signed [COORD_W-1:0] origin;
  logic signed [COORD_W:0]   diff;
  logic [GRID_REG_W-1:0]     lim;
  logic [DIV_W-1:0]          quo;
  logic                      div_done;
  logic                      at_end;
  logic [CW-1:0]             cell_val;

  logic [CW-1:0]        x0, y0, x1, y1;
  logic                 x_up, y_up;
  logic signed [EW-1:0] dx, dy, err;
  logic [CW-1:0]        adx, ady;
  logic signed [EW:0]   e2;
  logic                 mv_x, mv_y;

  assign world  = pt[cmd.sel];
  assign origin = cmd.sel[0] ? cfg.origin_y : cfg.origin_x;
  assign lim    = cmd.sel[0] ? cfg.grid_h : cfg.grid_w;
  assign diff   = (COORD_W+1)'(world) - (COORD_W+1)'(origin);

  glr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (diff[DIV_W-1:0]),
    .divisor  (cfg.cell_size),
    .quotient (quo),
    .done     (div_done)
  );

  // negative offsets floor below zero and clamp to the first cell; offsets past the grid clamp to the last cell
  always_comb begin
    if (diff[COORD_W])
      cell_val = '0;
    else if (quo >= DIV_W'(lim))
      cell_val = CW'(lim - GRID_REG_W'(1));
    else
      cell_val = quo[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pt[0] <= start_x;
      pt[1] <= start_y;
      pt[2] <= end_x;
      pt[3] <= end_y;
    end
  end

  assign adx  = (x1 > x0) ? x1 - x0 : x0 - x1;
  assign ady  = (y1 > y0) ? y1 - y0 : y0 - y1;
  assign e2   = {err, 1'b0};
  assign mv_x = e2 >= (EW+1)'(dy);
  assign mv_y = e2 <= (EW+1)'(dx);

  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      unique case (cmd.sel)
        2'd0: x0 <= cell_val;
        2'd1: y0 <= cell_val;
        2'd2: x1 <= cell_val;
        2'd3: y1 <= cell_val;
      endcase
    end else if (cmd.setup) begin
      dx   <= signed'(EW'(adx));
      dy   <= -signed'(EW'(ady));
      err  <= signed'(EW'(adx)) - signed'(EW'(ady));
      x_up <= x0 < x1;
      y_up <= y0 < y1;
    end else if (cmd.step) begin
      err <= err + (mv_x ? dy : EW'(0)) + (mv_y ? dx : EW'(0));
      if (mv_x)
        x0 <= x_up ? x0 + CW'(1) : x0 - CW'(1);
      if (mv_y)
        y0 <= y_up ? y0 + CW'(1) : y0 - CW'(1);
    end
  end

  assign at_end    = (x0 == x1) && (y0 == y1);
  assign status    = '{div_done: div_done, at_end: at_end};
  assign cell_x    = CELL_W'(x0);
  assign cell_y    = CELL_W'(y0);
  assign last_cell = at_end;

endmodule

FILE: rtl/core/glr_ctrl.sv
// Controller: sequences the four divisions, setup and cell emission
module glr_ctrl import glr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state, state_next;
  logic [1:0]  sel, sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel   <= '0;
    end else begin
      state <= state_next;
      sel   <= sel_next;
    end
  end

  always_comb begin
    state_next    = state;
    sel_next      = sel;
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    cmd           = '0;
    cmd.sel       = sel;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          sel_next   = '0;
          state_next = S_DIV_START;
        end
      end
      S_DIV_START: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (status.div_done) begin
          cmd.div_store = 1'b1;
          sel_next      = sel + 2'd1;
          state_next    = (sel == 2'd3) ? S_SETUP : S_DIV_START;
        end
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (status.at_end)
            state_next = S_IDLE;
          else
            cmd.step = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/core/grid_line_rasterizer.sv
// Sequence: each endpoint coordinate passes through the shared bit-serial divider,
//   four coordinates in turn, then the setup state, before the first cell.
// Throughput: then one cell per cycle while taken; a new segment is taken only
//   after the last cell of the current one has been taken and the block is idle.
// Reset: synchronous, active high; returns to idle and loads the register defaults.
module grid_line_rasterizer import glr_pkg::*; #(
  parameter int MAX_GRID = MAX_GRID_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  glr_seg_if.sink               line_seg,
  glr_cell_if.source            grid_cell,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  assign pready = 1'b1;

  glr_cfg #(.MAX_GRID(MAX_GRID)) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  glr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (line_seg.valid),
    .in_ready  (line_seg.ready),
    .out_valid (grid_cell.valid),
    .out_ready (grid_cell.ready),
    .status    (status),
    .cmd       (cmd)
  );

  glr_dp #(.MAX_GRID(MAX_GRID)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .status    (status),
    .start_x   (line_seg.start_x),
    .start_y   (line_seg.start_y),
    .end_x     (line_seg.end_x),
    .end_y     (line_seg.end_y),
    .cell_x    (grid_cell.cell_x),
    .cell_y    (grid_cell.cell_y),
    .last_cell (grid_cell.last_cell)
  );

endmodule

FILE: rtl/core/glr_checker.sv
// Port-level checks of the rasteriser, bound to the top level
module glr_checker import glr_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CELL_W-1:0] cell_x,
  input logic [CELL_W-1:0] cell_y,
  input logic              last_cell
);

  a_no_cell_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid)
    else $error("cell offered right after a segment was taken");

  a_busy_while_emitting: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("segment taken while cells are still pending");

  a_run_ends_at_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_cell |=> !out_valid)
    else $error("cell offered after the last cell of a segment");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cell_x) && $stable(cell_y)
      && $stable(last_cell))
    else $error("stalled cell changed");

endmodule

bind grid_line_rasterizer glr_checker u_glr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (line_seg.valid),
  .in_ready  (line_seg.ready),
  .out_valid (grid_cell.valid),
  .out_ready (grid_cell.ready),
  .cell_x    (grid_cell.cell_x),
  .cell_y    (grid_cell.cell_y),
  .last_cell (grid_cell.last_cell)
);
